FILE: src/chained_hash_map_assert.svh
// Assertion macros for the checker module.
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// Clocked property, held off during reset.
`define CHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define CHM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/chm_pkg.sv
package chm_pkg;

    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int MODE_W      = 2;
    localparam int USED_W      = 11;
    localparam int BUCKET_W_MX = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [VALUE_W-1:0] VALUE_NONE = '1;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [KEY_W-1:0]       key;
        logic [VALUE_W-1:0]     value;
        logic [BUCKET_W_MX-1:0] bucket;
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD_RD,
        BK_HEAD_CHK,
        BK_ENT_CHK,
        BK_ACT
    } back_state_t;

endpackage

FILE: src/chm_ram.sv
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/chm_queue.sv
module chm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  chm_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output chm_pkg::op_t  pop_op,
    output logic          empty
);

    chm_pkg::op_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/chm_front.sv
module chm_front #(
    parameter int NUM_BUCKETS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clearing,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [chm_pkg::MODE_W-1:0]    in_mode,
    input  logic [chm_pkg::KEY_W-1:0]     in_key,
    input  logic [chm_pkg::VALUE_W-1:0]   in_value,
    output logic                          push,
    output chm_pkg::op_t                  push_op,
    input  logic                          q_full
);

    localparam int  BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam bit  IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    localparam logic [BW:0]   NB_C   = (BW + 1)'(NUM_BUCKETS);
    localparam logic [BW-1:0] MASK_C = BW'(NUM_BUCKETS - 1);

    chm_pkg::front_state_t          state_reg;
    chm_pkg::front_state_t          state_next;
    logic [chm_pkg::MODE_W-1:0]     mode_reg;
    logic [chm_pkg::KEY_W-1:0]      key_reg;
    logic [chm_pkg::VALUE_W-1:0]    value_reg;
    logic [chm_pkg::KEY_W-1:0]      fold_reg;
    logic [chm_pkg::KEY_W-1:0]      fold_next;
    logic [BW:0]                    rem_reg;
    logic [BW:0]                    rem_next;
    logic [BW-1:0]                  bucket_reg;
    logic [BW-1:0]                  bucket_next;
    logic [3:0]                     digit_reg;
    logic [3:0]                     digit_next;
    logic [chm_pkg::KEY_W-1:0]      fold_in;
    logic [BW:0]                    rem_step;
    logic                           accept;

    assign fold_in = {in_key[63:32], in_key[31:0] ^ in_key[63:32]};
    assign accept  = in_valid && in_ready;

    always_comb
    begin
        rem_step = rem_reg;
        for (int j = 0; j < 4; j++)
        begin
            rem_step = {rem_step[BW-1:0], fold_reg[63 - j]};
            if (rem_step >= NB_C)
            begin
                rem_step = rem_step - NB_C;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fold_next   = fold_reg;
        rem_next    = rem_reg;
        digit_next  = digit_reg;
        bucket_next = bucket_reg;
        in_ready    = 1'b0;
        push        = 1'b0;
        case (state_reg)
            chm_pkg::FR_IDLE:
            begin
                in_ready = !clearing;
                if (accept)
                begin
                    fold_next   = fold_in;
                    rem_next    = '0;
                    digit_next  = '0;
                    bucket_next = fold_in[BW-1:0] & MASK_C;
                    state_next  = IS_POW2 ? chm_pkg::FR_PUSH : chm_pkg::FR_HASH;
                end
            end
            chm_pkg::FR_HASH:
            begin
                fold_next  = {fold_reg[59:0], 4'd0};
                rem_next   = rem_step;
                digit_next = digit_reg + 4'd1;
                if (digit_reg == 4'd15)
                begin
                    bucket_next = rem_step[BW-1:0];
                    state_next  = chm_pkg::FR_PUSH;
                end
            end
            chm_pkg::FR_PUSH:
            begin
                push = 1'b1;
                if (!q_full)
                begin
                    state_next = chm_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = chm_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_op        = '0;
        push_op.mode   = mode_reg;
        push_op.key    = key_reg;
        push_op.value  = value_reg;
        push_op.bucket = chm_pkg::BUCKET_W_MX'(bucket_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_mode;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        fold_reg   <= fold_next;
        rem_reg    <= rem_next;
        bucket_reg <= bucket_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::FR_IDLE;
            digit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            digit_reg <= digit_next;
        end
    end

endmodule

FILE: src/chm_back.sv
module chm_back #(
    parameter int NUM_BUCKETS = 256,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    output logic                           clearing,
    input  logic                           q_empty,
    input  chm_pkg::op_t                   q_op,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [chm_pkg::VALUE_W-1:0]    out_read_value,
    output logic                           out_hit,
    output logic                           out_table_full,
    output logic [chm_pkg::USED_W-1:0]     out_entries_used
);

    localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW   = $clog2(MAX_ENTRIES + 1);
    localparam int CLR_N = (NUM_BUCKETS > MAX_ENTRIES) ? NUM_BUCKETS : MAX_ENTRIES;
    localparam int CW   = $clog2(CLR_N + 1);
    localparam int KO   = 0;
    localparam int VO   = chm_pkg::KEY_W;
    localparam int LO   = chm_pkg::KEY_W + chm_pkg::VALUE_W;
    localparam int EW   = LO + SW;
    localparam logic [SW-1:0] NIL_C  = SW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CLR_NB = CW'(NUM_BUCKETS);
    localparam logic [CW-1:0] CLR_ME = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

    chm_pkg::back_state_t          state_reg;
    chm_pkg::back_state_t          state_next;
    logic [CW-1:0]                 clr_reg;
    logic [CW-1:0]                 clr_next;
    logic [SW-1:0]                 count_reg;
    logic [SW-1:0]                 count_next;
    chm_pkg::op_t                  op_reg;
    chm_pkg::op_t                  op_next;
    logic [SW-1:0]                 head_reg;
    logic [SW-1:0]                 head_next;
    logic [SW-1:0]                 cur_reg;
    logic [SW-1:0]                 cur_next;
    logic [SW-1:0]                 prev_reg;
    logic [SW-1:0]                 prev_next;
    logic [EW-1:0]                 word_reg;
    logic [EW-1:0]                 word_next;
    logic [EW-1:0]                 prev_word_reg;
    logic [EW-1:0]                 prev_word_next;
    logic                          found_reg;
    logic                          found_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [chm_pkg::VALUE_W-1:0]   rd_reg;
    logic [chm_pkg::VALUE_W-1:0]   rd_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          full_reg;
    logic                          full_next;

    logic                          head_we;
    logic [BW-1:0]                 head_waddr;
    logic [SW-1:0]                 head_wdata;
    logic [SW-1:0]                 head_rdata;
    logic                          ent_we;
    logic [AW-1:0]                 ent_waddr;
    logic [EW-1:0]                 ent_wdata;
    logic [AW-1:0]                 ent_raddr;
    logic [EW-1:0]                 ent_rdata;
    logic                          free_we;
    logic [AW-1:0]                 free_waddr;
    logic [AW-1:0]                 free_wdata;
    logic [AW-1:0]                 free_rdata;
    logic [SW-1:0]                 ent_link;
    logic [SW-1:0]                 count_dec;
    logic                          out_free;

    chm_ram #(.WIDTH(SW), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (op_reg.bucket[BW-1:0]),
        .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    chm_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (count_reg[AW-1:0]),
        .rdata (free_rdata)
    );

    assign clearing         = (state_reg == chm_pkg::BK_CLEAR);
    assign ent_link         = ent_rdata[LO +: SW];
    assign count_dec        = count_reg - SW'(1);
    assign out_free         = !valid_reg || out_ready;
    assign out_valid        = valid_reg;
    assign out_read_value   = rd_reg;
    assign out_hit          = hit_reg;
    assign out_table_full   = full_reg;
    assign out_entries_used = chm_pkg::USED_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        word_next      = word_reg;
        prev_word_next = prev_word_reg;
        found_next     = found_reg;
        valid_next     = valid_reg && !out_ready;
        rd_next        = rd_reg;
        hit_next       = hit_reg;
        full_next      = full_reg;
        pop            = 1'b0;
        head_we        = 1'b0;
        head_waddr     = op_reg.bucket[BW-1:0];
        head_wdata     = NIL_C;
        ent_we         = 1'b0;
        ent_waddr      = cur_reg[AW-1:0];
        ent_wdata      = word_reg;
        ent_raddr      = cur_reg[AW-1:0];
        free_we        = 1'b0;
        free_waddr     = count_dec[AW-1:0];
        free_wdata     = cur_reg[AW-1:0];
        case (state_reg)
            chm_pkg::BK_CLEAR:
            begin
                head_we    = (clr_reg < CLR_NB);
                head_waddr = clr_reg[BW-1:0];
                free_we    = (clr_reg < CLR_ME);
                free_waddr = clr_reg[AW-1:0];
                free_wdata = clr_reg[AW-1:0];
                clr_next   = clr_reg + CW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = chm_pkg::BK_IDLE;
                end
            end
            chm_pkg::BK_IDLE:
            begin
                pop = !q_empty;
                if (!q_empty)
                begin
                    op_next    = q_op;
                    found_next = 1'b0;
                    if (q_op.mode inside {chm_pkg::MODE_INSERT, chm_pkg::MODE_LOOKUP,
                                          chm_pkg::MODE_DELETE})
                    begin
                        state_next = chm_pkg::BK_HEAD_RD;
                    end
                    else
                    begin
                        state_next = chm_pkg::BK_ACT;
                    end
                end
            end
            chm_pkg::BK_HEAD_RD:
            begin
                state_next = chm_pkg::BK_HEAD_CHK;
            end
            chm_pkg::BK_HEAD_CHK:
            begin
                head_next = head_rdata;
                cur_next  = head_rdata;
                prev_next = NIL_C;
                ent_raddr = head_rdata[AW-1:0];
                if (head_rdata >= NIL_C)
                begin
                    state_next = chm_pkg::BK_ACT;
                end
                else
                begin
                    state_next = chm_pkg::BK_ENT_CHK;
                end
            end
            chm_pkg::BK_ENT_CHK:
            begin
                ent_raddr = ent_link[AW-1:0];
                if (ent_rdata[KO +: chm_pkg::KEY_W] == op_reg.key)
                begin
                    found_next = 1'b1;
                    word_next  = ent_rdata;
                    state_next = chm_pkg::BK_ACT;
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_word_next = ent_rdata;
                    cur_next       = ent_link;
                    if (ent_link >= NIL_C)
                    begin
                        state_next = chm_pkg::BK_ACT;
                    end
                end
            end
            chm_pkg::BK_ACT:
            begin
                if (out_free)
                begin
                    rd_next    = chm_pkg::VALUE_NONE;
                    hit_next   = found_reg;
                    full_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = chm_pkg::BK_IDLE;
                    case (op_reg.mode)
                        chm_pkg::MODE_INSERT:
                        begin
                            if (found_reg)
                            begin
                                ent_we    = 1'b1;
                                ent_wdata = {word_reg[LO +: SW], op_reg.value, op_reg.key};
                            end
                            else if (count_reg >= NIL_C)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_waddr  = free_rdata;
                                ent_wdata  = {head_reg, op_reg.value, op_reg.key};
                                head_we    = 1'b1;
                                head_wdata = SW'(free_rdata);
                                count_next = count_reg + SW'(1);
                            end
                        end
                        chm_pkg::MODE_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                rd_next = word_reg[VO +: chm_pkg::VALUE_W];
                            end
                        end
                        chm_pkg::MODE_DELETE:
                        begin
                            if (found_reg && (count_reg != '0))
                            begin
                                if (prev_reg < NIL_C)
                                begin
                                    ent_we    = 1'b1;
                                    ent_waddr = prev_reg[AW-1:0];
                                    ent_wdata = {word_reg[LO +: SW], prev_word_reg[LO-1:0]};
                                end
                                else
                                begin
                                    head_we    = 1'b1;
                                    head_wdata = word_reg[LO +: SW];
                                end
                                free_we    = 1'b1;
                                count_next = count_dec;
                            end
                        end
                        default:
                        begin
                            hit_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = chm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        head_reg      <= head_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        word_reg      <= word_next;
        prev_word_reg <= prev_word_next;
        found_reg     <= found_next;
        rd_reg        <= rd_next;
        hit_reg       <= hit_next;
        full_reg      <= full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::BK_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: src/chained_hash_map.sv
// Hash map of 64-bit keys to 32-bit values, chained buckets over a fixed entry pool.
// Input stream s_axis: one word per request; tuser carries the operation
// (insert or update, lookup, delete, or none), tdata the key and the value.
// Output stream m_axis: exactly one result word per request, in request order.
// A front stage takes a request and computes its bucket (the folded key
// masked for a power-of-two bucket count, else its remainder by long
// division), then hands it over a two-entry queue to the back stage,
// which walks the bucket chain in RAM. The back stage handles one request
// at a time: it pops it, reads and checks the bucket head, then visits the
// chain entries one by one until the key matches or the chain ends, and
// finally acts on the request and writes the result register. The front
// stage can take a new request while the back stage is busy with another.
// After reset the block sweeps the bucket and free-slot RAMs, one address per
// cycle over every bucket and every slot, with s_axis_tready low.
// When m_axis_tready is low the result register holds; the queue and front
// stage keep taking requests until they fill, then s_axis_tready drops.
module chained_hash_map #(
    parameter int NUM_BUCKETS = 256,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // key[63:0], value[95:64]
    input  logic [1:0]   s_axis_tuser,   // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata    // read_value[31:0], hit[32], table_full[33],
                                         // entries_used[44:34], zero[47:45]
);

    logic                           clearing;
    logic                           q_push;
    chm_pkg::op_t                   q_push_op;
    logic                           q_full;
    logic                           q_pop;
    chm_pkg::op_t                   q_pop_op;
    logic                           q_empty;
    logic [chm_pkg::VALUE_W-1:0]    read_value;
    logic                           hit;
    logic                           table_full;
    logic [chm_pkg::USED_W-1:0]     entries_used;

    chm_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_key   (s_axis_tdata[63:0]),
        .in_value (s_axis_tdata[95:64]),
        .push     (q_push),
        .push_op  (q_push_op),
        .q_full   (q_full)
    );

    chm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_pop_op),
        .empty   (q_empty)
    );

    chm_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .clearing         (clearing),
        .q_empty          (q_empty),
        .q_op             (q_pop_op),
        .pop              (q_pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_read_value   (read_value),
        .out_hit          (hit),
        .out_table_full   (table_full),
        .out_entries_used (entries_used)
    );

    assign m_axis_tdata = {3'd0, entries_used, table_full, hit, read_value};

endmodule

FILE: src/chm_checker.sv
`include "chained_hash_map_assert.svh"

module chm_checker #(
    parameter int MAX_ENTRIES = 1024
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [95:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata
);

    `CHM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
    `CHM_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    `CHM_ASSERT(a_full_miss, m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]), "full flagged on a hit")
    `CHM_ASSERT(a_value_hit, m_axis_tvalid && (m_axis_tdata[31:0] != 32'hFFFF_FFFF) |-> m_axis_tdata[32], "value without hit")
    `CHM_ASSERT(a_count_range, m_axis_tvalid |-> (m_axis_tdata[44:34] <= 11'(MAX_ENTRIES)), "count beyond pool")

endmodule

bind chained_hash_map chm_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_chm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/chained_hash_map_tb.sv
`timescale 1ns / 100ps

module chained_hash_map_tb;

    localparam int NBKT = 256;
    localparam int NENT = 1024;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] read_value;
        logic        hit;
        logic        table_full;
        logic [10:0] entries_used;
    } map_result_t;

    class map_scoreboard;
        logic [10:0] heads [NBKT];
        logic [63:0] keys [NENT];
        logic [31:0] vals [NENT];
        logic [10:0] links [NENT];
        logic [9:0]  free_slots [NENT];
        int unsigned count;
        map_result_t pending [$];
        int errors;

        function new();
            for (int i = 0; i < NBKT; i++) heads[i] = 11'(NENT);
            for (int i = 0; i < NENT; i++)
            begin
                links[i] = 11'(NENT);
                free_slots[i] = 10'(i);
            end
            count = 0;
            errors = 0;
        endfunction

        function void note_request(logic [1:0] mode, logic [63:0] key, logic [31:0] value);
            map_result_t r;
            logic [63:0] folded;
            int b, cur, prev, slot, steps, s;
            r.read_value = chm_pkg::VALUE_NONE;
            r.hit = 0;
            r.table_full = 0;
            if (mode != chm_pkg::MODE_NONE)
            begin
                folded = key ^ (key >> 32);
                b = int'(folded % NBKT);
                cur = heads[b];
                prev = NENT;
                slot = NENT;
                steps = 0;
                while (cur < NENT && steps < NENT)
                begin
                    if (keys[cur] == key)
                    begin
                        slot = cur;
                        break;
                    end
                    prev = cur;
                    cur = links[cur];
                    steps++;
                end
                if (slot == NENT) prev = NENT;
                r.hit = slot < NENT;
                if (mode == chm_pkg::MODE_INSERT)
                begin
                    if (r.hit)
                        vals[slot] = value;
                    else if (count >= NENT)
                        r.table_full = 1;
                    else
                    begin
                        s = free_slots[count];
                        keys[s] = key;
                        vals[s] = value;
                        links[s] = heads[b];
                        heads[b] = 11'(s);
                        count++;
                    end
                end
                else if (mode == chm_pkg::MODE_LOOKUP)
                begin
                    if (r.hit) r.read_value = vals[slot];
                end
                else if (r.hit && count > 0)
                begin
                    if (prev < NENT) links[prev] = links[slot];
                    else heads[b] = links[slot];
                    count--;
                    free_slots[count] = 10'(slot);
                end
            end
            r.entries_used = count[10:0];
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [47:0] word);
            map_result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", word[31:0], 0);
                return;
            end
            want = pending.pop_front();
            if (word[31:0] !== want.read_value) report("read_value", word[31:0], want.read_value);
            if (word[32] !== want.hit) report("hit", word[32], want.hit);
            if (word[33] !== want.table_full) report("table_full", word[33], want.table_full);
            if (word[44:34] !== want.entries_used)
                report("entries_used", word[44:34], want.entries_used);
            if (word[47:45] !== 3'd0) report("pad", word[47:45], 0);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // key[63:0], value[95:64]
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_value[31:0], hit[32], table_full[33], entries_used[44:34]

    map_scoreboard sb;
    int  stall_cycles;
    bit  calm;
    logic [63:0] key_pool [32];

    chained_hash_map #(.NUM_BUCKETS(NBKT), .MAX_ENTRIES(NENT)) dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("chained_hash_map test failed");
                $finish;
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    task send_word(logic [1:0] mode, logic [63:0] key, logic [31:0] value);
        while (!calm && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {value, key};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(mode, key, value);
    endtask

    task drain;
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [1:0] m;
        logic [63:0] k;
        sb = new();
        stall_cycles = 0;
        calm = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 0;
        for (int i = 0; i < 32; i++) key_pool[i] = rand_key();
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        key_pool[2] = 64'h0000_0001_0000_0001;
        key_pool[3] = 64'h0000_0100_0000_0000;
        @(posedge rst_n);
        @(posedge clk);

        send_word(chm_pkg::MODE_LOOKUP, 64'd0, 32'd0);
        send_word(chm_pkg::MODE_DELETE, '1, '1);
        send_word(chm_pkg::MODE_INSERT, 64'd0, '1);
        send_word(chm_pkg::MODE_INSERT, '1, 32'd0);
        send_word(chm_pkg::MODE_INSERT, key_pool[2], 32'h1234_5678);
        send_word(chm_pkg::MODE_INSERT, key_pool[3], 32'hdead_beef);
        send_word(chm_pkg::MODE_LOOKUP, 64'd0, 32'd5);
        send_word(chm_pkg::MODE_LOOKUP, '1, 32'd5);
        send_word(chm_pkg::MODE_LOOKUP, key_pool[3], 32'd0);
        send_word(chm_pkg::MODE_INSERT, key_pool[2], 32'hcafe_f00d);
        send_word(chm_pkg::MODE_LOOKUP, key_pool[2], 32'd0);
        send_word(chm_pkg::MODE_NONE, key_pool[2], 32'd7);
        send_word(chm_pkg::MODE_DELETE, key_pool[2], 32'd0);
        send_word(chm_pkg::MODE_LOOKUP, key_pool[2], 32'd0);
        send_word(chm_pkg::MODE_DELETE, key_pool[2], 32'd0);
        send_word(chm_pkg::MODE_DELETE, 64'd0, 32'd0);
        drain();

        for (int n = 0; n < 400; n++)
        begin
            calm = (n >= 100 && n < 250);
            m = ($urandom_range(99) < 3) ? chm_pkg::MODE_NONE : 2'($urandom_range(2));
            k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(31)] : rand_key();
            send_word(m, k, $urandom);
            if (n == 200) drain();
        end
        calm = 0;

        for (int n = 0; n < NENT + 40; n++)
            send_word(chm_pkg::MODE_INSERT, {$urandom, 22'd0, n[9:0]}, $urandom);
        for (int n = 0; n < 120; n++)
            send_word(2'($urandom_range(2)), key_pool[$urandom_range(31)], $urandom);
        for (int n = 0; n < 200; n++)
            send_word(chm_pkg::MODE_DELETE, rand_key(), 32'd0);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("chained_hash_map test passed");
        else
            $display("chained_hash_map test failed");
        $finish;
    end
endmodule

FILE: chained_hash_map.f
+incdir+src
src/chm_pkg.sv
src/chm_ram.sv
src/chm_queue.sv
src/chm_front.sv
src/chm_back.sv
src/chained_hash_map.sv
src/chm_checker.sv
test/chained_hash_map_tb.sv
